### rtl/core/adq_pkg.sv
// ----------------------------------------------------------------------------
// adq_pkg
// Shared types, codes and sizes for the array-based double-ended queue.
// ----------------------------------------------------------------------------
package adq_pkg;

   localparam int DEPTH       = 8;
   localparam int ADDR_W      = $clog2(DEPTH);
   // signed index: holds -1 up to DEPTH
   localparam int IDX_W       = $clog2(DEPTH + 1) + 1;
   localparam int DATA_W      = 32;

   localparam int CMDQ_DEPTH  = 2;
   localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

   localparam int RSPQ_DEPTH  = 4;
   localparam int RSPQ_PTR_W  = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W  = $clog2(RSPQ_DEPTH + 1);

   typedef logic signed [IDX_W-1:0]  idx_type;
   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [ADDR_W-1:0]        addr_type;

   localparam idx_type IDX_NONE  = idx_type'(-1);
   localparam idx_type IDX_ZERO  = idx_type'(0);
   localparam idx_type IDX_ONE   = idx_type'(1);
   localparam idx_type IDX_LAST  = idx_type'(DEPTH - 1);

   // command codes on the request port
   localparam logic [2:0] CMD_INS_FRONT = 3'd0;
   localparam logic [2:0] CMD_INS_REAR  = 3'd1;
   localparam logic [2:0] CMD_DEL_FRONT = 3'd2;
   localparam logic [2:0] CMD_DEL_REAR  = 3'd3;
   localparam logic [2:0] CMD_DUMP      = 3'd4;

   // status codes on the response port
   localparam logic [1:0] ST_OK            = 2'd0;
   localparam logic [1:0] ST_FULL_REAR     = 2'd1;
   localparam logic [1:0] ST_NO_ROOM_FRONT = 2'd2;
   localparam logic [1:0] ST_EMPTY         = 2'd3;

   typedef enum logic [2:0] {
      OP_INS_FRONT,
      OP_INS_REAR,
      OP_DEL_FRONT,
      OP_DEL_REAR,
      OP_DUMP
   } op_type;

   typedef enum logic {
      EX_IDLE,
      EX_DUMP
   } ex_state_type;

   typedef struct packed {
      op_type   op;
      data_type value;
   } cmd_type;

   typedef struct packed {
      logic [1:0] status;
      data_type   value;
      logic       last;
   } rsp_type;

endpackage

### rtl/core/adq_cmd_front.sv
// ----------------------------------------------------------------------------
// adq_cmd_front
// Request side: decodes command beats and holds them in a short queue.
// ----------------------------------------------------------------------------
module adq_cmd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [2:0]        req_command,
   input  adq_pkg::data_type req_item_value,
   input  logic              cmd_pop,
   output logic              cmd_empty,
   output adq_pkg::cmd_type  cmd_head
);
   import adq_pkg::*;

   cmd_type                cmdq_mem [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]  count_ff, count_in;
   logic                   accept;
   logic                   op_valid;
   op_type                 op_dec;
   logic                   push_q;
   logic                   pop_q;

   // classify; unused codes are accepted and dropped here
   always_comb begin
      op_valid = 1'b1;
      op_dec   = OP_INS_FRONT;
      case (req_command)
         CMD_INS_FRONT: op_dec = OP_INS_FRONT;
         CMD_INS_REAR:  op_dec = OP_INS_REAR;
         CMD_DEL_FRONT: op_dec = OP_DEL_FRONT;
         CMD_DEL_REAR:  op_dec = OP_DEL_REAR;
         CMD_DUMP:      op_dec = OP_DUMP;
         default:       op_valid = 1'b0;
      endcase
   end

   assign req_full  = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign cmd_empty = (count_ff == '0);
   assign accept    = req_push && !req_full;
   assign push_q    = accept && op_valid;
   assign pop_q     = cmd_pop && !cmd_empty;
   assign cmd_head  = cmdq_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_q ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_q  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_q && !pop_q) begin
         count_in = count_ff + 1'b1;
      end else if (pop_q && !push_q) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_q) begin
         cmdq_mem[wr_ptr_ff] <= '{op: op_dec, value: req_item_value};
      end
   end

endmodule

### rtl/core/adq_exec.sv
// ----------------------------------------------------------------------------
// adq_exec
// Back end: owns the slot array and indices, runs commands and dump walks.
// ----------------------------------------------------------------------------
module adq_exec (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_empty,
   input  adq_pkg::cmd_type              cmd_head,
   output logic                          cmd_pop,
   input  logic [adq_pkg::RSPQ_CNT_W-1:0] rsp_count,
   output logic                          rsp_push,
   output adq_pkg::rsp_type              rsp_data
);
   import adq_pkg::*;

   data_type      slots_mem [DEPTH];
   data_type      rdata_ff;

   ex_state_type  state_ff, state_in;
   idx_type       front_ff, front_in;
   idx_type       rear_ff, rear_in;
   idx_type       ptr_ff, ptr_in;

   // result stage, registered together with the slot read data
   logic          res_valid_ff, res_valid_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic          res_last_ff, res_last_in;
   logic          res_mem_ff, res_mem_in;

   logic          mem_we;
   addr_type      mem_waddr;
   logic          mem_re;
   addr_type      mem_raddr;
   logic          q_empty;
   logic          space_ok;
   logic [RSPQ_CNT_W:0] occupancy;

   assign q_empty   = (front_ff == IDX_NONE) || (front_ff > rear_ff);
   // count the beat sitting in the result stage against queue room
   assign occupancy = {1'b0, rsp_count} + {{RSPQ_CNT_W{1'b0}}, res_valid_ff};
   assign space_ok  = occupancy < (RSPQ_CNT_W + 1)'(RSPQ_DEPTH);

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      ptr_in        = ptr_ff;
      cmd_pop       = 1'b0;
      res_valid_in  = 1'b0;
      res_status_in = ST_OK;
      res_last_in   = 1'b1;
      res_mem_in    = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      case (state_ff)
         EX_IDLE: begin
            if (!cmd_empty && space_ok) begin
               cmd_pop      = 1'b1;
               res_valid_in = 1'b1;
               case (cmd_head.op)
                  OP_INS_FRONT: begin
                     if (front_ff == IDX_ZERO) begin
                        res_status_in = ST_NO_ROOM_FRONT;
                     end else if (q_empty) begin
                        front_in  = IDX_ZERO;
                        rear_in   = IDX_ZERO;
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                     end else begin
                        front_in  = front_ff - IDX_ONE;
                        mem_we    = 1'b1;
                        mem_waddr = front_in[ADDR_W-1:0];
                     end
                  end
                  OP_INS_REAR: begin
                     if (rear_ff >= IDX_LAST) begin
                        res_status_in = ST_FULL_REAR;
                     end else begin
                        if (front_ff == IDX_NONE) begin
                           front_in = IDX_ZERO;
                        end
                        rear_in   = rear_ff + IDX_ONE;
                        mem_we    = 1'b1;
                        mem_waddr = rear_in[ADDR_W-1:0];
                     end
                  end
                  OP_DEL_FRONT: begin
                     if (q_empty) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        mem_re     = 1'b1;
                        mem_raddr  = front_ff[ADDR_W-1:0];
                        res_mem_in = 1'b1;
                        front_in   = front_ff + IDX_ONE;
                     end
                  end
                  OP_DEL_REAR: begin
                     if (q_empty) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        mem_re     = 1'b1;
                        mem_raddr  = rear_ff[ADDR_W-1:0];
                        res_mem_in = 1'b1;
                        rear_in    = rear_ff - IDX_ONE;
                     end
                  end
                  OP_DUMP: begin
                     if (q_empty) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        mem_re      = 1'b1;
                        mem_raddr   = front_ff[ADDR_W-1:0];
                        res_mem_in  = 1'b1;
                        res_last_in = (front_ff == rear_ff);
                        if (front_ff != rear_ff) begin
                           ptr_in   = front_ff + IDX_ONE;
                           state_in = EX_DUMP;
                        end
                     end
                  end
                  default: res_valid_in = 1'b0;
               endcase
            end
         end
         EX_DUMP: begin
            if (space_ok) begin
               res_valid_in = 1'b1;
               mem_re       = 1'b1;
               mem_raddr    = ptr_ff[ADDR_W-1:0];
               res_mem_in   = 1'b1;
               res_last_in  = (ptr_ff == rear_ff);
               ptr_in       = ptr_ff + IDX_ONE;
               if (ptr_ff == rear_ff) begin
                  state_in = EX_IDLE;
               end
            end
         end
         default: state_in = EX_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EX_IDLE;
         front_ff     <= IDX_NONE;
         rear_ff      <= IDX_NONE;
         ptr_ff       <= IDX_ZERO;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         ptr_ff       <= ptr_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_last_ff   <= res_last_in;
      res_mem_ff    <= res_mem_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slots_mem[mem_waddr] <= cmd_head.value;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= slots_mem[mem_raddr];
      end
   end

   assign rsp_push        = res_valid_ff;
   assign rsp_data.status = res_status_ff;
   assign rsp_data.value  = res_mem_ff ? rdata_ff : '0;
   assign rsp_data.last   = res_last_ff;

endmodule

### rtl/core/adq_rsp_queue.sv
// ----------------------------------------------------------------------------
// adq_rsp_queue
// Response side: holds result beats until the receiver pops them.
// ----------------------------------------------------------------------------
module adq_rsp_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rsp_push,
   input  adq_pkg::rsp_type               rsp_data,
   output logic [adq_pkg::RSPQ_CNT_W-1:0] rsp_count,
   input  logic                           rsp_pop,
   output logic                           rsp_empty,
   output adq_pkg::rsp_type               rsp_head
);
   import adq_pkg::*;

   rsp_type                rspq_mem [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RSPQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSPQ_CNT_W-1:0]  count_ff, count_in;
   logic                   pop_q;

   // the back end only pushes when it has reserved room
   assign rsp_empty = (count_ff == '0);
   assign rsp_count = count_ff;
   assign pop_q     = rsp_pop && !rsp_empty;
   assign rsp_head  = rspq_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = rsp_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_q    ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (rsp_push && !pop_q) begin
         count_in = count_ff + 1'b1;
      end else if (pop_q && !rsp_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rspq_mem[wr_ptr_ff] <= rsp_data;
      end
   end

endmodule

### rtl/core/array_double_ended_queue.sv
// ----------------------------------------------------------------------------
// array_double_ended_queue
// Linear array deque with front/rear insert, front/rear delete and dump.
// ----------------------------------------------------------------------------
// Request channel: a beat is taken when req_push is high and req_full low.
//   req_command picks the operation; req_item_value is used by inserts.
//   Codes five to seven are taken and dropped without a response.
// Response channel: the oldest beat sits on rsp_* while rsp_empty is low
//   and leaves when rsp_pop is high. Inserts and deletes give one beat;
//   a dump gives one beat per stored element, front to rear, rsp_last on
//   the final one, or a single empty-status beat.
// Path: a request beat passes through the command queue, the result stage
//   and the response queue, each registered, before it shows on rsp_*.
// Throughput: one command per cycle for inserts and deletes; a dump holds
//   the back end until it has read all stored elements, up to DEPTH, one
//   slot array read per cycle. Both wait while the response queue is full.
// Stalls: a 2-entry command queue and a 4-entry response queue sit on
//   either side of the back end; when the receiver stops popping, the
//   response queue fills, the back end waits and req_full rises.
// Reset: front and rear indices go to minus one (queue empty); both queues
//   are cleared. Slot contents are not cleared.
// ----------------------------------------------------------------------------
module array_double_ended_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [2:0]          req_command,
   input  logic signed [31:0]  req_item_value,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [1:0]          rsp_status,
   output logic signed [31:0]  rsp_value,
   output logic                rsp_last
);
   import adq_pkg::*;

   logic                   cmd_empty;
   logic                   cmd_pop;
   cmd_type                cmd_head;
   logic                   res_push;
   rsp_type                res_data;
   logic [RSPQ_CNT_W-1:0]  res_count;
   rsp_type                rsp_head;

   adq_cmd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_command    (req_command),
      .req_item_value (req_item_value),
      .cmd_pop        (cmd_pop),
      .cmd_empty      (cmd_empty),
      .cmd_head       (cmd_head)
   );

   adq_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_count (res_count),
      .rsp_push  (res_push),
      .rsp_data  (res_data)
   );

   adq_rsp_queue u_rspq (
      .clock     (clock),
      .reset     (reset),
      .rsp_push  (res_push),
      .rsp_data  (res_data),
      .rsp_count (res_count),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_head  (rsp_head)
   );

   assign rsp_status = rsp_head.status;
   assign rsp_value  = rsp_head.value;
   assign rsp_last   = rsp_head.last;

endmodule
